FILE: rtl/core/fvps_pkg.sv
// Shared types and codes for the four-voice pulse and noise synthesizer.
`timescale 1ns / 1ps

package fvps_pkg;

  // Request action codes.
  localparam logic [1:0] ACT_TICK      = 2'd0;
  localparam logic [1:0] ACT_WRITE_ALL = 2'd1;
  localparam logic [1:0] ACT_WRITE_DV  = 2'd2;
  localparam logic [1:0] ACT_READ      = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_CALLBACK_ENABLE = 3'd0;
  localparam logic [2:0] CFG_TICK_PRESET_0   = 3'd1;
  localparam logic [2:0] CFG_TICK_PRESET_1   = 3'd2;
  localparam logic [2:0] CFG_DC_OFFSET       = 3'd3;
  localparam logic [2:0] CFG_TICK_RELOAD     = 3'd4;

  // Reset values.
  localparam logic [7:0]  DUTY_RESET      = 8'h7F;
  localparam logic [15:0] LFSR_RESET      = 16'h0001;
  localparam logic [7:0]  PRESCALER_RESET = 8'd255;
  localparam logic [7:0]  DC_RESET        = 8'd128;
  localparam logic [7:0]  RELOAD_RESET    = 8'd8;

  localparam int unsigned NUM_VOICES = 4;
  localparam int unsigned NUM_PULSE  = 3;
  localparam int unsigned NUM_TICKS  = 2;

  // Configuration register file contents.
  typedef struct packed {
    logic [1:0] callback_enable;
    logic [7:0] tick_preset_0;
    logic [7:0] tick_preset_1;
    logic [7:0] dc_offset;
    logic [7:0] tick_reload;
  } cfg_t;

  // Controls from the top level to the voice bank.
  typedef struct packed {
    logic        sample_en;
    logic        wr_step;
    logic        wr_duty_vol;
    logic [1:0]  idx;
    logic [15:0] step;
    logic [7:0]  duty;
    logic [7:0]  vol;
  } voice_ctrl_t;

  // Outcome of one tick from the tick controller.
  typedef struct packed {
    logic       sample_en;
    logic [1:0] fired;
  } tick_res_t;

endpackage

FILE: rtl/core/fvps_tick_ctrl.sv
// Interrupt counter and the two tick prescalers.
`timescale 1ns / 1ps

module fvps_tick_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               tick_i,
  input  fvps_pkg::cfg_t     cfg_i,
  output fvps_pkg::tick_res_t res_o
);

  logic [7:0] irq_q, irq_d;
  logic [7:0] tc_q [fvps_pkg::NUM_TICKS];
  logic [7:0] tc_d [fvps_pkg::NUM_TICKS];
  logic [7:0] irq_dec;
  logic [7:0] tc_dec [fvps_pkg::NUM_TICKS];
  logic [7:0] preset [fvps_pkg::NUM_TICKS];
  logic [1:0] wrapped;
  logic       active;
  logic       sample_go;
  logic       rollover;

  assign preset[0] = cfg_i.tick_preset_0;
  assign preset[1] = cfg_i.tick_preset_1;

  // A tick counts only while some channel is enabled; even counts make a sample.
  assign active    = tick_i && (cfg_i.callback_enable != 2'd0);
  assign irq_dec   = irq_q - 8'd1;
  assign sample_go = active && !irq_dec[0];
  assign rollover  = sample_go && (irq_dec == 8'd0);

  always_comb begin
    irq_d = irq_q;
    if (active) begin
      irq_d = rollover ? cfg_i.tick_reload : irq_dec;
    end
  end

  // Prescalers step on rollover; reload and fire only when one of them wrapped.
  always_comb begin
    res_o.sample_en = sample_go;
    res_o.fired     = '0;
    for (int n = 0; n < fvps_pkg::NUM_TICKS; n++) begin
      wrapped[n] = (tc_q[n] == 8'd0);
      tc_dec[n]  = tc_q[n] - 8'd1;
      tc_d[n]    = tc_q[n];
    end
    if (rollover) begin
      for (int n = 0; n < fvps_pkg::NUM_TICKS; n++) begin
        if (wrapped == 2'b00) begin
          tc_d[n] = tc_dec[n];
        end else if (wrapped[n]) begin
          tc_d[n]        = preset[n];
          res_o.fired[n] = cfg_i.callback_enable[n];
        end else begin
          tc_d[n] = cfg_i.callback_enable[n] ? tc_dec[n] : fvps_pkg::PRESCALER_RESET;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_q <= 8'd0;
      for (int n = 0; n < fvps_pkg::NUM_TICKS; n++) begin
        tc_q[n] <= fvps_pkg::PRESCALER_RESET;
      end
    end else begin
      irq_q <= irq_d;
      for (int n = 0; n < fvps_pkg::NUM_TICKS; n++) begin
        tc_q[n] <= tc_d[n];
      end
    end
  end

endmodule

FILE: rtl/core/fvps_voice_bank.sv
// Voice parameter storage, phase accumulators, noise LFSR and the voice mixer.
`timescale 1ns / 1ps

module fvps_voice_bank (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fvps_pkg::voice_ctrl_t ctrl_i,
  output logic [7:0]            mix_o,
  output logic [15:0]           rd_step_o,
  output logic [7:0]            rd_duty_o,
  output logic [7:0]            rd_vol_o
);

  logic [15:0] acc_q   [fvps_pkg::NUM_PULSE];
  logic [15:0] acc_sum [fvps_pkg::NUM_PULSE];
  logic [15:0] step_q  [fvps_pkg::NUM_VOICES];
  logic [7:0]  duty_q  [fvps_pkg::NUM_VOICES];
  logic [7:0]  vol_q   [fvps_pkg::NUM_VOICES];
  logic [7:0]  contrib [fvps_pkg::NUM_VOICES];
  logic [15:0] lfsr_d;

  // Noise voice: shift left, feedback from the new top two bits.
  assign lfsr_d = {step_q[3][14:0], step_q[3][14] ^ step_q[3][13]};

  // Pulse voices advance the phase and compare its high byte with the duty.
  // The noise voice takes its sign from the new top bit.
  always_comb begin
    for (int v = 0; v < fvps_pkg::NUM_PULSE; v++) begin
      acc_sum[v] = acc_q[v] + step_q[v];
      contrib[v] = (acc_sum[v][15:8] < duty_q[v]) ? vol_q[v] : 8'd0 - vol_q[v];
    end
    contrib[3] = lfsr_d[15] ? 8'd0 - vol_q[3] : vol_q[3];
  end

  assign mix_o = contrib[0] + contrib[1] + contrib[2] + contrib[3];

  // Read-back of the addressed voice.
  assign rd_step_o = step_q[ctrl_i.idx];
  assign rd_duty_o = duty_q[ctrl_i.idx];
  assign rd_vol_o  = vol_q[ctrl_i.idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < fvps_pkg::NUM_PULSE; v++) begin
        acc_q[v]  <= 16'd0;
        step_q[v] <= 16'd0;
      end
      for (int v = 0; v < fvps_pkg::NUM_VOICES; v++) begin
        duty_q[v] <= fvps_pkg::DUTY_RESET;
        vol_q[v]  <= 8'd0;
      end
      step_q[3] <= fvps_pkg::LFSR_RESET;
    end else begin
      if (ctrl_i.sample_en) begin
        for (int v = 0; v < fvps_pkg::NUM_PULSE; v++) begin
          acc_q[v] <= acc_sum[v];
        end
        step_q[3] <= lfsr_d;
      end
      if (ctrl_i.wr_step) begin
        step_q[ctrl_i.idx] <= ctrl_i.step;
      end
      if (ctrl_i.wr_duty_vol) begin
        duty_q[ctrl_i.idx] <= ctrl_i.duty;
        vol_q[ctrl_i.idx]  <= ctrl_i.vol;
      end
    end
  end

endmodule

FILE: rtl/core/four_voice_pulse_noise_synth_core.sv
// Top level of the four-voice pulse and noise synthesizer core.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------------
//   request  | in_valid_i / in_ready_o   | action, osc_index, new_phase_increment,
//            |                           | new_mod, new_vol
//   result   | out_valid_o / out_ready_i | sample_valid, sample, tick_fired,
//            |                           | read_phase_increment, read_mod, read_vol
//   config   | cfg_we_i (no wait)        | cfg_idx_i, cfg_wdata_i
//
// Each request is captured in the input register, then the voice bank and tick
// controller settle the whole result in one pass into the result register. One
// request per cycle is sustained while out_ready_i stays high. Reset puts every
// voice, counter and configuration register to its initial value at once. A
// stalled result holds both registers; the input register still takes one
// request, then in_ready_o stays low until the result is taken (in_ready_o
// follows out_ready_i in the same cycle).
`timescale 1ns / 1ps

module four_voice_pulse_noise_synth_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [1:0]  osc_index_i,
  input  logic [15:0] new_phase_increment_i,
  input  logic [7:0]  new_mod_i,
  input  logic [7:0]  new_vol_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        sample_valid_o,
  output logic [7:0]  sample_o,
  output logic [1:0]  tick_fired_o,
  output logic [15:0] read_phase_increment_o,
  output logic [7:0]  read_mod_o,
  output logic [7:0]  read_vol_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i
);

  fvps_pkg::cfg_t        cfg_q;
  fvps_pkg::voice_ctrl_t vctrl;
  fvps_pkg::tick_res_t   tres;

  logic        in_valid_q;
  logic [1:0]  action_q;
  logic [1:0]  idx_q;
  logic [15:0] inc_q;
  logic [7:0]  mod_q;
  logic [7:0]  vol_q;

  logic        out_valid_q;
  logic        smp_valid_q;
  logic [7:0]  sample_q;
  logic [1:0]  fired_q;
  logic [15:0] rd_step_q;
  logic [7:0]  rd_duty_q;
  logic [7:0]  rd_vol_q;

  logic        advance;
  logic        process;
  logic        is_read;
  logic [7:0]  mix;
  logic [15:0] rd_step;
  logic [7:0]  rd_duty;
  logic [7:0]  rd_vol;

  // Pipeline flow: the result register frees up when empty or being taken.
  assign advance    = !out_valid_q || out_ready_i;
  assign process    = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;
  assign is_read    = (action_q == fvps_pkg::ACT_READ);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.callback_enable <= 2'd0;
      cfg_q.tick_preset_0   <= fvps_pkg::PRESCALER_RESET;
      cfg_q.tick_preset_1   <= fvps_pkg::PRESCALER_RESET;
      cfg_q.dc_offset       <= fvps_pkg::DC_RESET;
      cfg_q.tick_reload     <= fvps_pkg::RELOAD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fvps_pkg::CFG_CALLBACK_ENABLE: cfg_q.callback_enable <= cfg_wdata_i[1:0];
        fvps_pkg::CFG_TICK_PRESET_0:   cfg_q.tick_preset_0   <= cfg_wdata_i;
        fvps_pkg::CFG_TICK_PRESET_1:   cfg_q.tick_preset_1   <= cfg_wdata_i;
        fvps_pkg::CFG_DC_OFFSET:       cfg_q.dc_offset       <= cfg_wdata_i;
        fvps_pkg::CFG_TICK_RELOAD:     cfg_q.tick_reload     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      action_q <= action_i;
      idx_q    <= osc_index_i;
      inc_q    <= new_phase_increment_i;
      mod_q    <= new_mod_i;
      vol_q    <= new_vol_i;
    end
  end

  fvps_tick_ctrl u_tick_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (process && (action_q == fvps_pkg::ACT_TICK)),
    .cfg_i  (cfg_q),
    .res_o  (tres)
  );

  // Voice bank controls for the request in the input register.
  always_comb begin
    vctrl.sample_en   = tres.sample_en;
    vctrl.wr_step     = process && (action_q == fvps_pkg::ACT_WRITE_ALL);
    vctrl.wr_duty_vol = process && ((action_q == fvps_pkg::ACT_WRITE_ALL) ||
                                    (action_q == fvps_pkg::ACT_WRITE_DV));
    vctrl.idx         = idx_q;
    vctrl.step        = inc_q;
    vctrl.duty        = mod_q;
    vctrl.vol         = vol_q;
  end

  fvps_voice_bank u_voice_bank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (vctrl),
    .mix_o     (mix),
    .rd_step_o (rd_step),
    .rd_duty_o (rd_duty),
    .rd_vol_o  (rd_vol)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      smp_valid_q <= tres.sample_en;
      sample_q    <= tres.sample_en ? mix + cfg_q.dc_offset : 8'd0;
      fired_q     <= tres.fired;
      rd_step_q   <= is_read ? rd_step : 16'd0;
      rd_duty_q   <= is_read ? rd_duty : 8'd0;
      rd_vol_q    <= is_read ? rd_vol : 8'd0;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign sample_valid_o         = smp_valid_q;
  assign sample_o               = sample_q;
  assign tick_fired_o           = fired_q;
  assign read_phase_increment_o = rd_step_q;
  assign read_mod_o             = rd_duty_q;
  assign read_vol_o             = rd_vol_q;

endmodule
